// ===== design/hforro14_key_derivation_defines.svh =====
// ----------------------------------------------------------------------------
// HForro14 key derivation: assertion macros
// Concurrent assertion wrappers on clock/reset; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef HFORRO14_KEY_DERIVATION_DEFINES_SVH
`define HFORRO14_KEY_DERIVATION_DEFINES_SVH

`ifndef SYNTHESIS

`define HFKD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hfkd: assertion failed");

`define HFKD_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hfkd: reset assertion failed");

`else

`define HFKD_ASSERT(label, prop)

`define HFKD_ASSERT_RST(label, prop)

`endif

`endif

// ===== design/hfkd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 key derivation package
// Shared types, constants and the Forro mixing functions.
// ----------------------------------------------------------------------------
package hfkd_pkg;

   localparam int WORD_W            = 32;
   localparam int NUM_WORDS         = 16;
   localparam int FIELD_W           = 64;
   localparam int NUM_KEYS          = 4;
   localparam int CSR_INDEX_W       = 8;
   localparam int QR_PER_ROUND      = 8;
   localparam int QR_OPERANDS       = 5;
   localparam int DOUBLE_ROUNDS_DEF = 7;
   localparam int QUEUE_DEPTH_DEF   = 2;

   typedef logic [WORD_W-1:0]       word_type;
   typedef logic [3:0]              idx_type;
   typedef word_type [NUM_WORDS-1:0] state_type;
   typedef logic [FIELD_W-1:0]      field_type;
   typedef field_type [NUM_KEYS-1:0] key_array_type;
   typedef logic [CSR_INDEX_W-1:0]  csr_index_type;

   typedef struct packed {
      logic      valid;
      state_type state;
   } stage_bus_type;

   localparam csr_index_type KEY_WORD0_IDX = 8'd0;
   localparam csr_index_type KEY_WORD1_IDX = 8'd1;
   localparam csr_index_type KEY_WORD2_IDX = 8'd2;
   localparam csr_index_type KEY_WORD3_IDX = 8'd3;

   localparam word_type SIGMA0 = 32'h746C6F76;
   localparam word_type SIGMA1 = 32'h61616461;
   localparam word_type SIGMA2 = 32'h72626173;
   localparam word_type SIGMA3 = 32'h61636E61;

   localparam int ROT_A = 10;
   localparam int ROT_B = 27;
   localparam int ROT_C = 8;

   // operands a, b, c, d, e of each quarter-round within a double round
   localparam idx_type QR_TABLE [QR_PER_ROUND][QR_OPERANDS] = '{
      '{4'd0, 4'd4, 4'd8,  4'd12, 4'd3},
      '{4'd1, 4'd5, 4'd9,  4'd13, 4'd0},
      '{4'd2, 4'd6, 4'd10, 4'd14, 4'd1},
      '{4'd3, 4'd7, 4'd11, 4'd15, 4'd2},
      '{4'd0, 4'd5, 4'd10, 4'd15, 4'd3},
      '{4'd1, 4'd6, 4'd11, 4'd12, 4'd0},
      '{4'd2, 4'd7, 4'd8,  4'd13, 4'd1},
      '{4'd3, 4'd4, 4'd9,  4'd14, 4'd2}
   };

   function automatic word_type rotl(word_type v, int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic state_type build_state(key_array_type key, field_type nonce_low,
                                             field_type nonce_high);
      state_type w;
      w[0]  = key[0][31:0];
      w[1]  = key[0][63:32];
      w[2]  = key[1][31:0];
      w[3]  = key[1][63:32];
      w[4]  = nonce_low[31:0];
      w[5]  = nonce_low[63:32];
      w[6]  = SIGMA0;
      w[7]  = SIGMA1;
      w[8]  = key[2][31:0];
      w[9]  = key[2][63:32];
      w[10] = key[3][31:0];
      w[11] = key[3][63:32];
      w[12] = nonce_high[31:0];
      w[13] = nonce_high[63:32];
      w[14] = SIGMA2;
      w[15] = SIGMA3;
      return w;
   endfunction

   // one half of the quarter-round: three dependent adds
   function automatic state_type half_qr(state_type w_in, idx_type a, idx_type b,
                                         idx_type c, idx_type d, idx_type e,
                                         logic second);
      state_type w;
      w = w_in;
      if (!second) begin
         w[d] = w[d] + w[e];
         w[c] = w[c] ^ w[d];
         w[b] = rotl(w[b] + w[c], ROT_A);
         w[a] = w[a] + w[b];
         w[e] = w[e] ^ w[a];
      end else begin
         w[d] = rotl(w[d] + w[e], ROT_B);
         w[c] = w[c] + w[d];
         w[b] = w[b] ^ w[c];
         w[a] = rotl(w[a] + w[b], ROT_C);
      end
      return w;
   endfunction

endpackage

// ===== design/hfkd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 request channel
// Valid/ready channel carrying the 128-bit derivation input.
// ----------------------------------------------------------------------------
interface hfkd_req_if;
   import hfkd_pkg::*;

   logic      valid;
   logic      ready;
   field_type nonce_low;
   field_type nonce_high;

   modport source (output valid, output nonce_low, output nonce_high, input ready);
   modport sink   (input valid, input nonce_low, input nonce_high, output ready);
endinterface

// ===== design/hfkd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 response channel
// Valid/ready channel carrying the 256-bit subkey as four 64-bit parts.
// ----------------------------------------------------------------------------
interface hfkd_rsp_if;
   import hfkd_pkg::*;

   logic      valid;
   logic      ready;
   field_type subkey_part0;
   field_type subkey_part1;
   field_type subkey_part2;
   field_type subkey_part3;

   modport source (output valid, output subkey_part0, output subkey_part1,
                   output subkey_part2, output subkey_part3, input ready);
   modport sink   (input valid, input subkey_part0, input subkey_part1,
                   input subkey_part2, input subkey_part3, output ready);
endinterface

// ===== design/hfkd_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 register write channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hfkd_csr_if;
   import hfkd_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   field_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hfkd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 front end
// Holds the key registers, accepts requests and builds the initial state.
// ----------------------------------------------------------------------------
module hfkd_front (
   input  logic                   clock,
   input  logic                   reset,
   hfkd_req_if.sink               req_chan,
   hfkd_csr_if.sink               csr_chan,
   output hfkd_pkg::stage_bus_type push_out,
   input  logic                   push_ready
);
   import hfkd_pkg::*;

   key_array_type key_ff;
   key_array_type key_in;
   logic          valid_ff;
   logic          valid_in;
   state_type     state_ff;
   state_type     state_in;
   logic          accept;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      key_in = key_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            KEY_WORD0_IDX: key_in[0] = csr_chan.data;
            KEY_WORD1_IDX: key_in[1] = csr_chan.data;
            KEY_WORD2_IDX: key_in[2] = csr_chan.data;
            KEY_WORD3_IDX: key_in[3] = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      state_in = state_ff;
      if (accept) begin
         valid_in = 1'b1;
         state_in = build_state(key_ff, req_chan.nonce_low, req_chan.nonce_high);
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         key_ff   <= key_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign push_out.valid = valid_ff;
   assign push_out.state = state_ff;

endmodule

// ===== design/hfkd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 state queue
// Short FIFO of initial states between the front end and the round pipeline.
// ----------------------------------------------------------------------------
module hfkd_queue #(
   parameter int DEPTH = hfkd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hfkd_pkg::stage_bus_type push_in,
   output logic                    push_ready,
   output hfkd_pkg::stage_bus_type head_out,
   input  logic                    pop
);
   import hfkd_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEVEL_W = $clog2(DEPTH + 1);

   state_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic               push;

   assign push_ready     = level_ff != LEVEL_W'(DEPTH);
   assign push           = push_in.valid && push_ready;
   assign head_out.valid = level_ff != '0;
   assign head_out.state = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_in.state;
      end
   end

endmodule

// ===== design/hfkd_rounds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 round pipeline
// One half quarter-round per stage; the last stage is the response register.
// ----------------------------------------------------------------------------
module hfkd_rounds #(
   parameter int DOUBLE_ROUNDS = hfkd_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hfkd_pkg::stage_bus_type head_in,
   output logic                    pop,
   hfkd_rsp_if.source              rsp_chan
);
   import hfkd_pkg::*;

   localparam int STAGES = 2 * QR_PER_ROUND * DOUBLE_ROUNDS;

   logic      valid_ff [STAGES];
   state_type data_ff  [STAGES];
   state_type data_in  [STAGES];
   logic      advance;

   assign advance = !valid_ff[STAGES-1] || rsp_chan.ready;
   assign pop     = advance && head_in.valid;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int   QR     = (s / 2) % QR_PER_ROUND;
      localparam logic SECOND = ((s % 2) == 1);
      if (s == 0) begin : g_first
         assign data_in[s] = half_qr(head_in.state, QR_TABLE[QR][0], QR_TABLE[QR][1],
                                     QR_TABLE[QR][2], QR_TABLE[QR][3], QR_TABLE[QR][4],
                                     SECOND);
      end else begin : g_next
         assign data_in[s] = half_qr(data_ff[s-1], QR_TABLE[QR][0], QR_TABLE[QR][1],
                                     QR_TABLE[QR][2], QR_TABLE[QR][3], QR_TABLE[QR][4],
                                     SECOND);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= head_in.valid;
         for (int i = 1; i < STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STAGES; i++) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   assign rsp_chan.valid        = valid_ff[STAGES-1];
   assign rsp_chan.subkey_part0 = {data_ff[STAGES-1][5],  data_ff[STAGES-1][4]};
   assign rsp_chan.subkey_part1 = {data_ff[STAGES-1][7],  data_ff[STAGES-1][6]};
   assign rsp_chan.subkey_part2 = {data_ff[STAGES-1][13], data_ff[STAGES-1][12]};
   assign rsp_chan.subkey_part3 = {data_ff[STAGES-1][15], data_ff[STAGES-1][14]};

endmodule

// ===== design/hforro14_key_derivation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HForro14 key derivation
// Derives a 256-bit subkey from the 256-bit key and a 128-bit input.
//
//   channel   dir  payload                          handshake
//   req_chan  in   nonce_low, nonce_high            valid/ready
//   rsp_chan  out  subkey_part0 .. subkey_part3     valid/ready
//   csr_chan  in   index, data (key_word0..3)       valid/ready, always ready
//
// One transaction enters per cycle unless a stalled response holds the pipeline;
// a result passes the front register, the queue and the round pipeline.
// Reset clears the key to zero; no clearing pass.
// A stalled response freezes the pipeline; the queue absorbs requests until
// it and the front register fill, then req_chan.ready drops.
// ----------------------------------------------------------------------------
`include "hforro14_key_derivation_defines.svh"

module hforro14_key_derivation #(
   parameter int DOUBLE_ROUNDS = hfkd_pkg::DOUBLE_ROUNDS_DEF,
   parameter int QUEUE_DEPTH   = hfkd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hfkd_req_if.sink   req_chan,
   hfkd_rsp_if.source rsp_chan,
   hfkd_csr_if.sink   csr_chan
);
   import hfkd_pkg::*;

   stage_bus_type push_bus;
   logic          push_ready;
   stage_bus_type head_bus;
   logic          pop;

   hfkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_out   (push_bus),
      .push_ready (push_ready)
   );

   hfkd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push_bus),
      .push_ready (push_ready),
      .head_out   (head_bus),
      .pop        (pop)
   );

   hfkd_rounds #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_rounds (
      .clock    (clock),
      .reset    (reset),
      .head_in  (head_bus),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   `HFKD_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_chan.valid)
   `HFKD_ASSERT(a_no_pop_on_stall, (rsp_chan.valid && !rsp_chan.ready) |-> !pop)
   `HFKD_ASSERT(a_accept_fills_front, (req_chan.valid && req_chan.ready) |=> push_bus.valid)
   `HFKD_ASSERT(a_queue_holds_head, (head_bus.valid && !pop) |=> head_bus.valid)

endmodule
